// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, ignored while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/uprm_pkg.sv -----
// ----------------------------------------------------------------------------
// UART port register model package
// Transaction types, opcodes, addresses and bit positions.
// ----------------------------------------------------------------------------
package uprm_pkg;

  localparam int CNT_W = 12;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_ARRIVE = 2'd3;

  localparam logic [7:0] ADDR_DATA = 8'hB1;
  localparam logic [7:0] ADDR_CTRL = 8'hB3;

  // control_bits holds register bits 7..4
  localparam int CTRL_ON   = 3;
  localparam int CTRL_FAST = 2;

  // write_value bits of the control register
  localparam int WR_CLR_OVR = 5;
  localparam int WR_ON      = 7;

  typedef struct packed {
    logic       cable_present;
    logic [7:0] arrived_byte;
    logic [7:0] write_value;
    logic [7:0] port_address;
    logic [1:0] opcode;
  } item_t;

  typedef struct packed {
    logic       recv_irq;
    logic       send_irq;
    logic [7:0] tx_byte;
    logic       tx_start;
    logic [7:0] read_value;
  } result_t;

endpackage

// ----- rtl/uart_port_register_model.sv -----
// ----------------------------------------------------------------------------
// UART port register model
// Bus reads, bus writes, line ticks and cable arrivals of a byte serial port.
// ----------------------------------------------------------------------------
// Path: each input transaction passes the input register, then the result
//   register; the port state updates as the item leaves the input
//   register.
// Throughput: one transaction per cycle, limited only by output backpressure.
// Reset: rst (synchronous, active high) clears all port state and flags and
//   empties both pipeline registers.
module uart_port_register_model #(
  parameter int CYCLES_PER_TICK  = 256,   // 1 .. 1024
  parameter int SLOW_BYTE_CYCLES = 3200,  // 1 .. 4095
  parameter int FAST_BYTE_CYCLES = 800    // 1 .. 4095
) (
  input  logic        clk,
  input  logic        rst,
  // input transaction
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: port_address[7:0], write_value[15:8], arrived_byte[23:16],
  //        cable_present[24], zero fill[31:25]
  input  logic [31:0] s_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]  s_tuser,
  // result transaction
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: read_value[7:0], tx_start[8], tx_byte[16:9], send_irq[17],
  //        recv_irq[18], zero fill[23:19]
  output logic [23:0] m_tdata
);
  import uprm_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    out_free;
  logic    adv;
  logic    s_fire;
  result_t res_next;
  result_t res;

  // The result register frees up when empty or being drained; the input
  // register moves forward whenever the result register can take it.
  assign out_free = !m_tvalid || m_tready;
  assign adv      = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;
  assign s_fire   = s_tvalid && s_tready;

  // Input register: capture the fields of each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_item.opcode        <= s_tuser;
      s1_item.port_address  <= s_tdata[7:0];
      s1_item.write_value   <= s_tdata[15:8];
      s1_item.arrived_byte  <= s_tdata[23:16];
      s1_item.cable_present <= s_tdata[24];
    end
  end

  // Port state; it advances exactly when an item moves to the result stage.
  uprm_core #(
    .CYCLES_PER_TICK  (CYCLES_PER_TICK),
    .SLOW_BYTE_CYCLES (SLOW_BYTE_CYCLES),
    .FAST_BYTE_CYCLES (FAST_BYTE_CYCLES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (adv),
    .item (s1_item),
    .res  (res_next)
  );

  // Result register: hold a finished result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

  assign m_tdata = {5'b0, res};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "assert_macros.svh"

  `ASSERT_CLK(a_tx_only_on_tick, (adv && res_next.tx_start) |-> (s1_item.opcode == OP_TICK), "tx_start on a non-tick transaction")
  `ASSERT_CLK(a_read_only_on_read, (adv && res_next.read_value != 8'd0) |-> (s1_item.opcode == OP_READ), "read data on a non-read transaction")
  `ASSERT_CLK(a_tx_keeps_buffer_full, (adv && res_next.tx_start) |-> !res_next.send_irq, "send interrupt while a byte starts")
  `ASSERT_CLK(a_stage_held, (s1_valid && !out_free) |=> s1_valid, "input stage dropped while stalled")

endmodule

// ----- rtl/uprm_core.sv -----
// ----------------------------------------------------------------------------
// UART port register core
// Port state and its next-state logic for one transaction.
// ----------------------------------------------------------------------------
module uprm_core #(
  parameter int CYCLES_PER_TICK  = 256,
  parameter int SLOW_BYTE_CYCLES = 3200,
  parameter int FAST_BYTE_CYCLES = 800
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  uprm_pkg::item_t item,
  output uprm_pkg::result_t res
);
  import uprm_pkg::*;

  logic [3:0]       control_bits, control_bits_next;
  logic [7:0]       send_buffer, send_buffer_next;
  logic [7:0]       recv_buffer, recv_buffer_next;
  logic             send_full, send_full_next;
  logic             recv_full, recv_full_next;
  logic             overrun_flag, overrun_flag_next;
  logic             shifting, shifting_next;
  logic [CNT_W-1:0] shift_cycles_left, shift_cycles_left_next;
  logic             port_on;
  logic [CNT_W-1:0] byte_time;

  assign port_on   = control_bits[CTRL_ON];
  assign byte_time = control_bits[CTRL_FAST] ? CNT_W'(FAST_BYTE_CYCLES)
                                             : CNT_W'(SLOW_BYTE_CYCLES);

  always_comb begin
    control_bits_next      = control_bits;
    send_buffer_next       = send_buffer;
    recv_buffer_next       = recv_buffer;
    send_full_next         = send_full;
    recv_full_next         = recv_full;
    overrun_flag_next      = overrun_flag;
    shifting_next          = shifting;
    shift_cycles_left_next = shift_cycles_left;
    res                    = '0;
    case (item.opcode)
      OP_READ: begin
        if (item.port_address == ADDR_DATA) begin
          recv_full_next = 1'b0;
          res.read_value = recv_buffer;
        end else if (item.port_address == ADDR_CTRL) begin
          res.read_value = {control_bits, 1'b0, port_on && !send_full,
                            overrun_flag, recv_full};
        end
      end
      OP_WRITE: begin
        if (item.port_address == ADDR_DATA) begin
          if (port_on && !send_full) begin
            send_buffer_next = item.write_value;
            send_full_next   = 1'b1;
          end
        end else if (item.port_address == ADDR_CTRL) begin
          if (item.write_value[WR_CLR_OVR]) overrun_flag_next = 1'b0;
          if (!item.write_value[WR_ON]) begin
            recv_full_next    = 1'b0;
            overrun_flag_next = 1'b0;
          end
          control_bits_next = item.write_value[7:4];
        end
      end
      OP_TICK: begin
        // count down even with the port off
        if (shifting) begin
          if ({1'b0, shift_cycles_left} > (CNT_W+1)'(CYCLES_PER_TICK))
            shift_cycles_left_next = shift_cycles_left - CNT_W'(CYCLES_PER_TICK);
          else
            shift_cycles_left_next = '0;
        end
        if (port_on) begin
          if (send_full && !shifting && !item.cable_present) begin
            send_full_next = 1'b0;
          end else begin
            if (send_full && !shifting) begin
              shifting_next          = 1'b1;
              shift_cycles_left_next = byte_time;
              res.tx_start           = 1'b1;
              res.tx_byte            = send_buffer;
            end
            if (shifting_next && shift_cycles_left_next == '0) begin
              shifting_next  = 1'b0;
              send_full_next = 1'b0;
            end
          end
        end
      end
      OP_ARRIVE: begin
        if (item.cable_present && port_on) begin
          if (recv_full) begin
            overrun_flag_next = 1'b1;
          end else begin
            recv_buffer_next = item.arrived_byte;
            recv_full_next   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res.send_irq = control_bits_next[CTRL_ON] && !send_full_next;
    res.recv_irq = recv_full_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_bits      <= '0;
      send_buffer       <= '0;
      recv_buffer       <= '0;
      send_full         <= 1'b0;
      recv_full         <= 1'b0;
      overrun_flag      <= 1'b0;
      shifting          <= 1'b0;
      shift_cycles_left <= '0;
    end else if (fire) begin
      control_bits      <= control_bits_next;
      send_buffer       <= send_buffer_next;
      recv_buffer       <= recv_buffer_next;
      send_full         <= send_full_next;
      recv_full         <= recv_full_next;
      overrun_flag      <= overrun_flag_next;
      shifting          <= shifting_next;
      shift_cycles_left <= shift_cycles_left_next;
    end
  end

endmodule

// ----- tb/uart_port_register_model_tb.sv -----
// ----------------------------------------------------------------------------
// UART port register model testbench
// Drives bus reads, bus writes, line ticks and cable arrivals into the port
// and checks every result against an in-bench shadow of the port registers.
// ----------------------------------------------------------------------------
module uart_port_register_model_tb;
  import uprm_pkg::*;

  localparam int TICK_CYCLES = 256;
  localparam int SLOW_BYTE   = 3200;
  localparam int FAST_BYTE   = 800;
  localparam int IDLE_LIMIT  = 2000;  // cycles without any transaction
  localparam int RANDOM_ITEMS = 450;

  // Shadow of the port registers. note_item advances the shadow on every
  // accepted input transaction and queues the result it must produce;
  // check_result compares each output transaction with the oldest entry.
  class port_shadow_sb;
    logic [3:0]       ctrl_bits  = '0;  // register bits 7..4
    logic [7:0]       tx_hold    = '0;
    logic [7:0]       rx_hold    = '0;
    logic             tx_full    = 1'b0;
    logic             rx_full    = 1'b0;
    logic             overrun    = 1'b0;
    logic             shifting   = 1'b0;
    logic [CNT_W-1:0] shift_left = '0;
    result_t          awaited_replies[$];
    int               errors     = 0;

    function void note_item(item_t it);
      result_t r;
      r = '0;
      case (it.opcode)
        OP_READ: begin
          if (it.port_address == ADDR_DATA) begin
            r.read_value = rx_hold;
            rx_full = 1'b0;
          end else if (it.port_address == ADDR_CTRL) begin
            r.read_value = {ctrl_bits, 1'b0, ctrl_bits[CTRL_ON] && !tx_full,
                            overrun, rx_full};
          end
        end
        OP_WRITE: begin
          if (it.port_address == ADDR_DATA) begin
            // latch only into an empty buffer of a running port
            if (ctrl_bits[CTRL_ON] && !tx_full) begin
              tx_hold = it.write_value;
              tx_full = 1'b1;
            end
          end else if (it.port_address == ADDR_CTRL) begin
            if (it.write_value[WR_CLR_OVR]) overrun = 1'b0;
            if (!it.write_value[WR_ON]) begin
              rx_full = 1'b0;
              overrun = 1'b0;
            end
            ctrl_bits = it.write_value[7:4];
          end
        end
        OP_TICK: begin
          // a byte in flight counts down even with the port off
          if (shifting)
            shift_left = (shift_left > TICK_CYCLES) ?
                         shift_left - CNT_W'(TICK_CYCLES) : '0;
          if (ctrl_bits[CTRL_ON]) begin
            if (tx_full && !shifting) begin
              if (!it.cable_present) begin
                tx_full = 1'b0;  // nobody listening: done at once
              end else begin
                shifting     = 1'b1;
                shift_left   = ctrl_bits[CTRL_FAST] ? CNT_W'(FAST_BYTE)
                                                    : CNT_W'(SLOW_BYTE);
                r.tx_start   = 1'b1;
                r.tx_byte    = tx_hold;
              end
            end
            if (shifting && shift_left == '0) begin
              shifting = 1'b0;
              tx_full  = 1'b0;
            end
          end
        end
        default: begin
          if (it.cable_present && ctrl_bits[CTRL_ON]) begin
            if (rx_full) begin
              overrun = 1'b1;
            end else begin
              rx_hold = it.arrived_byte;
              rx_full = 1'b1;
            end
          end
        end
      endcase
      r.send_irq = ctrl_bits[CTRL_ON] && !tx_full;
      r.recv_irq = rx_full;
      awaited_replies.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t: result with nothing awaited, got %h", $time, got);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time,
                 want.read_value, got.read_value);
        errors++;
      end
      if (got.tx_start !== want.tx_start) begin
        $display("%0t: tx_start expected %b actual %b", $time,
                 want.tx_start, got.tx_start);
        errors++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $display("%0t: tx_byte expected %h actual %h", $time,
                 want.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.send_irq !== want.send_irq) begin
        $display("%0t: send_irq expected %b actual %b", $time,
                 want.send_irq, got.send_irq);
        errors++;
      end
      if (got.recv_irq !== want.recv_irq) begin
        $display("%0t: recv_irq expected %b actual %b", $time,
                 want.recv_irq, got.recv_irq);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // tdata: port_address[7:0], write_value[15:8], arrived_byte[23:16],
  //        cable_present[24], zero fill[31:25]
  logic [31:0] s_tdata = '0;
  // tuser: opcode[1:0]
  logic [1:0]  s_tuser = OP_READ;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // tdata: read_value[7:0], tx_start[8], tx_byte[16:9], send_irq[17],
  //        recv_irq[18], zero fill[23:19]
  logic [23:0] m_tdata;

  port_shadow_sb sb = new();
  int            burst_left = 0;
  int            items_sent = 0;
  int            idle_cycles = 0;

  uart_port_register_model #(
    .CYCLES_PER_TICK (TICK_CYCLES),
    .SLOW_BYTE_CYCLES(SLOW_BYTE),
    .FAST_BYTE_CYCLES(FAST_BYTE)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one item and hold it until the port takes it. Bursts of random
  // length are separated by random gaps; valid drops only at a burst end.
  task automatic issue(input logic [1:0] op, input logic [7:0] addr,
                       input logic [7:0] wv, input logic [7:0] ab,
                       input logic cable);
    item_t it;
    int    gap;
    it.opcode        = op;
    it.port_address  = addr;
    it.write_value   = wv;
    it.arrived_byte  = ab;
    it.cable_present = cable;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, cable, ab, wv, addr};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  // Thin wrapper around issue; callers pass random don't-care fields, so unused bits still toggle.
  task automatic issue_op(input logic [1:0] op, input logic [7:0] addr,
                          input logic [7:0] wv, input logic [7:0] ab,
                          input logic cable);
    issue(op, addr, wv, ab, cable);
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic cable_mostly_on();
    return $urandom_range(0, 9) != 0;
  endfunction

  function automatic logic [7:0] reg_addr();
    return ($urandom_range(0, 1) == 0) ? ADDR_DATA : ADDR_CTRL;
  endfunction

  // Receiver: windows of random stall patterns, plus one long hold-off that
  // lets the pipeline fill while the sender keeps offering items.
  initial begin : result_sink
    int mode;
    int k;
    int windows;
    windows = 0;
    while (rst) @(posedge clk);
    forever begin
      if (windows == 12) begin
        m_tready <= 1'b0;
        for (k = 0; k < 300; k++) @(posedge clk);
      end
      windows++;
      mode = $urandom_range(0, 3);
      for (k = 0; k < 32; k++) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 0);
          2: m_tready <= (k % 4 == 0);
          default: m_tready <= (k % 4 != 3);
        endcase
        @(posedge clk);
      end
    end
  end

  // Check each result transaction as it is accepted.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(result_t'(m_tdata[18:0]));
  end

  // Watchdog: give up when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int         scene;
    int         n;
    logic [7:0] v;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset values, port-off behavior, both transmit paths,
    // switching off mid-byte, overrun and its clearing.
    issue(OP_READ,   ADDR_DATA, 8'h00, 8'h00, 1'b0);
    issue(OP_READ,   ADDR_CTRL, 8'hFF, 8'hFF, 1'b1);
    issue(OP_READ,   8'hFF,     8'h00, 8'h00, 1'b0);  // unmapped address
    issue(OP_WRITE,  ADDR_DATA, 8'h5A, 8'h00, 1'b1);  // port off: ignored
    issue(OP_TICK,   8'h00,     8'h00, 8'h00, 1'b1);
    issue(OP_ARRIVE, 8'h00,     8'h00, 8'h77, 1'b1);  // port off: dropped
    issue(OP_WRITE,  ADDR_CTRL, 8'hF0, 8'h00, 1'b0);  // on, fast, spares
    issue(OP_WRITE,  ADDR_DATA, 8'hFF, 8'h00, 1'b0);
    issue(OP_WRITE,  ADDR_DATA, 8'h11, 8'h00, 1'b0);  // buffer full: ignored
    issue(OP_TICK,   8'h00,     8'h00, 8'h00, 1'b0);  // no cable: done at once
    issue(OP_WRITE,  ADDR_DATA, 8'h00, 8'h00, 1'b1);
    issue(OP_TICK,   8'h00,     8'h00, 8'h00, 1'b1);  // starts, fast rate
    issue(OP_WRITE,  ADDR_CTRL, 8'h40, 8'h00, 1'b1);  // off while shifting
    issue(OP_TICK,   8'h00,     8'h00, 8'h00, 1'b1);
    issue(OP_TICK,   8'h00,     8'h00, 8'h00, 1'b1);
    issue(OP_WRITE,  ADDR_CTRL, 8'h80, 8'h00, 1'b1);  // back on, slow rate
    issue(OP_TICK,   8'h00,     8'h00, 8'h00, 1'b1);
    issue(OP_TICK,   8'h00,     8'h00, 8'h00, 1'b1);  // countdown hits zero
    issue(OP_ARRIVE, 8'h00,     8'h00, 8'hA5, 1'b1);
    issue(OP_ARRIVE, 8'h00,     8'h00, 8'h3C, 1'b1);  // buffer full: overrun
    issue(OP_ARRIVE, 8'h00,     8'h00, 8'hC3, 1'b0);  // no cable: dropped
    issue(OP_READ,   ADDR_CTRL, 8'h00, 8'h00, 1'b1);
    issue(OP_WRITE,  ADDR_CTRL, 8'hA0, 8'h00, 1'b1);  // clear overrun
    issue(OP_READ,   ADDR_DATA, 8'h00, 8'h00, 1'b1);
    issue(OP_WRITE,  8'h00,     8'hFF, 8'h00, 1'b1);  // unmapped: ignored

    // Random: mostly well-formed transmit and receive exchanges with random
    // content, with control rewrites and fully random noise mixed in.
    n = items_sent + RANDOM_ITEMS;
    while (items_sent < n) begin
      scene = $urandom_range(0, 99);
      if (scene < 25) begin
        issue_op(OP_WRITE, ADDR_DATA, rnd8(), rnd8(), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 14))
          issue_op(OP_TICK, rnd8(), rnd8(), rnd8(), cable_mostly_on());
      end else if (scene < 45) begin
        issue_op(OP_ARRIVE, rnd8(), rnd8(), rnd8(), cable_mostly_on());
        if ($urandom_range(0, 2) == 0)
          issue_op(OP_ARRIVE, rnd8(), rnd8(), rnd8(), cable_mostly_on());
        issue_op(OP_READ, ADDR_CTRL, rnd8(), rnd8(), 1'($urandom_range(0, 1)));
        issue_op(OP_READ, ADDR_DATA, rnd8(), rnd8(), 1'($urandom_range(0, 1)));
      end else if (scene < 60) begin
        v = rnd8();
        v[WR_ON] = ($urandom_range(0, 99) < 85);
        issue_op(OP_WRITE, ADDR_CTRL, v, rnd8(), 1'($urandom_range(0, 1)));
      end else if (scene < 85) begin
        issue_op(OP_READ, reg_addr(), rnd8(), rnd8(), 1'($urandom_range(0, 1)));
      end else begin
        issue_op(2'($urandom_range(0, 3)), rnd8(), rnd8(), rnd8(),
                 1'($urandom_range(0, 1)));
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then leave room for any stray result to show up.
    while (sb.awaited_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
